FILE: rtl/rlcs_pkg.sv
// Shared constants for the rotating LED column sequencer.
`default_nettype none

package rlcs_pkg;

    // Tick counter width; both counters wrap at this width.
    localparam int TICK_W = 32;

    // Defaults for the top-level parameters.
    localparam int COLUMNS_DEF        = 128;
    localparam int DURATION_SHIFT_DEF = 7;

    // Fixed payload widths.
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 7;
    localparam int BITS_W   = 16;
    localparam int DRIVE_W  = 8;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SENSOR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd2;

    // Port two bit 3 is held off.
    localparam logic [DRIVE_W-1:0] PORT_TWO_MASK = 8'hF7;

endpackage : rlcs_pkg

`default_nettype wire

FILE: rtl/rlcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : rlcs_ram

`default_nettype wire

FILE: rtl/rotating_led_column_sequencer.sv
// Top level of the rotating LED column sequencer.
`default_nettype none

// Persistence-of-vision column sequencer for a spinning LED bar. Each input
// transaction is a timer tick, a once-per-revolution sensor pulse, or a write
// of one pattern column. One transaction is taken every clock cycle; input
// stalls only while both result registers are full and the output is stalled.
// A sensor pulse loads the column duration with the last revolution's tick
// count shifted right by DURATION_SHIFT and clears both tick counters. A tick
// advances both counters; when the column counter then equals the duration
// exactly, the column index advances (wrapping to 0 after COLUMNS-2) and the
// inverted pattern of the old index plus one comes out: the pattern RAM
// read is registered at the accepting edge, and the output register loads
// when it is empty or its result is taken. A two-deep result path (RAM read
// stage plus output register) keeps input transactions flowing while a
// result waits on the output side. The pattern RAM has no reset: every column
// must be written before it is shown.

module rotating_led_column_sequencer
    import rlcs_pkg::*;
#(
    parameter int COLUMNS        = COLUMNS_DEF,
    parameter int DURATION_SHIFT = DURATION_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [ADDR_W-1:0]   i_column_addr,
    input  wire logic [BITS_W-1:0]   i_column_bits,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [DRIVE_W-1:0]  o_port_one_drive,
    output logic      [DRIVE_W-1:0]  o_port_two_drive,
    output logic      [ADDR_W-1:0]   o_shown_column
);

    localparam int IDX_W = $clog2(COLUMNS);
    localparam int DUR_W = TICK_W - DURATION_SHIFT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COLUMNS - 1);

    // Sequencer state
    logic [TICK_W-1:0] r_rev_ticks, n_rev_ticks;
    logic [TICK_W-1:0] r_col_ticks, n_col_ticks;
    logic [DUR_W-1:0]  r_duration, n_duration;
    logic [IDX_W-1:0]  r_col_idx, n_col_idx;

    // Result path: RAM read stage (a) and output register (b)
    logic              r_a_valid;
    logic [ADDR_W-1:0] r_a_col;
    logic              r_b_valid;
    logic [DRIVE_W-1:0] r_b_one;
    logic [DRIVE_W-1:0] r_b_two;
    logic [ADDR_W-1:0]  r_b_col;

    logic              accept;
    logic              a_move;
    logic              hit;
    logic              ram_we;
    logic [TICK_W-1:0] rev_inc;
    logic [TICK_W-1:0] col_inc;
    logic [IDX_W-1:0]  idx_inc;
    logic [31:0]       addr_wide;
    logic [31:0]       shown_wide;
    logic [BITS_W-1:0] ram_rdata;

    assign a_move     = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || a_move;
    assign accept     = i_in_valid && o_in_ready;

    assign rev_inc    = r_rev_ticks + TICK_W'(1);
    assign col_inc    = r_col_ticks + TICK_W'(1);
    // Index never rests at COLUMNS-1, so the increment cannot overflow
    assign idx_inc    = r_col_idx + IDX_W'(1);
    assign addr_wide  = 32'(i_column_addr);
    assign shown_wide = 32'(idx_inc);

    always_comb begin
        n_rev_ticks = r_rev_ticks;
        n_col_ticks = r_col_ticks;
        n_duration  = r_duration;
        n_col_idx   = r_col_idx;
        hit         = 1'b0;
        ram_we      = 1'b0;
        if (accept) begin
            case (i_action)
                ACT_TICK: begin
                    n_rev_ticks = rev_inc;
                    n_col_ticks = col_inc;
                    if (TICK_W'(r_duration) == col_inc) begin
                        hit         = 1'b1;
                        n_col_ticks = '0;
                        n_col_idx   = (idx_inc == LAST_IDX) ? '0 : idx_inc;
                    end
                end
                ACT_SENSOR: begin
                    n_duration  = r_rev_ticks[TICK_W-1:DURATION_SHIFT];
                    n_col_ticks = '0;
                    n_rev_ticks = '0;
                end
                ACT_WRITE: begin
                    ram_we = (addr_wide < 32'(COLUMNS));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_ticks <= '0;
            r_col_ticks <= '0;
            r_duration  <= '0;
            r_col_idx   <= '0;
        end else begin
            r_rev_ticks <= n_rev_ticks;
            r_col_ticks <= n_col_ticks;
            r_duration  <= n_duration;
            r_col_idx   <= n_col_idx;
        end
    end

    rlcs_ram #(
        .WIDTH (BITS_W),
        .DEPTH (COLUMNS)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr_wide[IDX_W-1:0]),
        .i_wdata (i_column_bits),
        .i_re    (hit),
        .i_raddr (idx_inc),
        .o_rdata (ram_rdata)
    );

    // Control of the result path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (hit) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload of the result path; RAM data holds until the next read
    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_a_col <= shown_wide[ADDR_W-1:0];
        end
        if (a_move) begin
            r_b_one <= ~ram_rdata[BITS_W-1:DRIVE_W];
            r_b_two <= ~ram_rdata[DRIVE_W-1:0] & PORT_TWO_MASK;
            r_b_col <= r_a_col;
        end
    end

    assign o_out_valid      = r_b_valid;
    assign o_port_one_drive = r_b_one;
    assign o_port_two_drive = r_b_two;
    assign o_shown_column   = r_b_col;

endmodule : rotating_led_column_sequencer

`default_nettype wire

FILE: rtl/rlcs_checker.sv
// Port-level assertions for the rotating LED column sequencer, with bind.
`default_nettype none

module rlcs_checker
    import rlcs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [ACTION_W-1:0] i_action,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [DRIVE_W-1:0] o_port_one_drive,
    input wire logic [DRIVE_W-1:0] o_port_two_drive,
    input wire logic [ADDR_W-1:0]  o_shown_column
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable({o_port_one_drive, o_port_two_drive, o_shown_column}))
        else $error("result payload changed while stalled");

    // Bit 3 of port two is driven low whenever a result is offered.
    a_bit3_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_port_two_drive & ~PORT_TWO_MASK) == '0))
        else $error("port two bit 3 driven high");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // A result only rises after an accepted tick.
    a_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_action == ACT_TICK), 2))
        else $error("result without a matching tick");

endmodule : rlcs_checker

bind rotating_led_column_sequencer rlcs_checker u_rlcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_action         (i_action),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_port_one_drive (o_port_one_drive),
    .o_port_two_drive (o_port_two_drive),
    .o_shown_column   (o_shown_column)
);

`default_nettype wire
